[sv/hegr_pkg.sv]
// Shared constants and types for the histogram equalize grey rule builder.
// Used by histogram_equalize_grey_rules_core; depends on nothing.
`default_nettype none

package hegr_pkg;

    localparam int TOTAL_BITS = 48;
    localparam int DIV_BITS   = TOTAL_BITS + 2;
    localparam int BIT_W      = $clog2(DIV_BITS);
    localparam int GREY_BITS  = 8;
    localparam int GREY_STEPS = GREY_BITS;
    localparam int STEP_W     = $clog2(GREY_STEPS);
    localparam int OP_BITS    = 2;
    localparam int CAT_BITS   = 32;
    localparam int CNT_BITS   = 32;
    localparam int IN_BITS    = CAT_BITS + CNT_BITS;
    localparam int OUT_BITS   = 2 * CAT_BITS + GREY_BITS;

    localparam logic [BIT_W-1:0]     BIT_LAST  = BIT_W'(DIV_BITS - 1);
    localparam logic [BIT_W-1:0]     TOT_LAST  = BIT_W'(TOTAL_BITS - 1);
    localparam logic [BIT_W-1:0]     TOT_LIM   = BIT_W'(TOTAL_BITS);
    localparam logic [STEP_W-1:0]    STEP_LAST = STEP_W'(GREY_STEPS - 1);
    localparam logic [GREY_BITS-1:0] GREY_MAX  = '1;

    localparam logic [OP_BITS-1:0] OP_TOTAL  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_MAP    = 2'd1;
    localparam logic [OP_BITS-1:0] OP_FINISH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_PREP,
        ST_DIV,
        ST_RULE,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

[sv/histogram_equalize_grey_rules_core.sv]
// Histogram equalize grey rule builder: bit-serial datapath, control and output register.
// Depends on hegr_pkg.
//
// The host streams the histogram twice. A pass-one word (tuser 0) adds its count to the
// total through the bit-serial adder. A pass-two word (tuser 1) with a positive count and
// a nonzero total runs one serial pass that builds the numerator, updates the running sum
// and compares, then eight serial subtract passes over the (TOTAL_BITS+2)-bit remainder
// that give the grey bits; these are skipped when the grey clamps to 255. The rule state
// follows, then the emit state when a run closes, which waits while the output register
// is still full. Other words are done in the idle state that accepts them. A finish word
// (tuser 2) emits the open run, if any, and clears the total, running sum and run state.
`default_nettype none

module histogram_equalize_grey_rules_core (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire  [hegr_pkg::IN_BITS-1:0]          s_axis_tdata,   // category, cell_count
    input  wire  [hegr_pkg::OP_BITS-1:0]          s_axis_tuser,   // operation
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    output logic [hegr_pkg::OUT_BITS-1:0]         m_axis_tdata    // rule_low, rule_high, rule_grey
);

    localparam int TB = hegr_pkg::TOTAL_BITS;
    localparam int DB = hegr_pkg::DIV_BITS;
    localparam int CB = hegr_pkg::CAT_BITS;
    localparam int NB = hegr_pkg::CNT_BITS;
    localparam int GB = hegr_pkg::GREY_BITS;

    hegr_pkg::t_state r_state, n_state;

    logic [hegr_pkg::OP_BITS-1:0] r_op;
    logic [CB-1:0]                r_cat;
    logic [NB-1:0]                r_cnt;
    logic [TB-1:0]                r_total;
    logic [TB-1:0]                r_sum;
    logic                         r_run_open;
    logic [CB-1:0]                r_run_start;
    logic [GB-1:0]                r_run_level;
    logic [CB-1:0]                r_last;
    logic [DB-1:0]                r_rem;
    logic [DB-1:0]                r_dif;
    logic [GB-1:0]                r_q;
    logic [hegr_pkg::BIT_W-1:0]   r_bit;
    logic [hegr_pkg::STEP_W-1:0]  r_step;
    logic                         r_ca, r_cb, r_bw, r_sd, r_td, r_rd;

    logic                         r_m_valid;
    logic [CB-1:0]                r_m_low;
    logic [CB-1:0]                r_m_high;
    logic [GB-1:0]                r_m_grey;

    logic [hegr_pkg::OP_BITS-1:0] w_op;
    logic [CB-1:0]                w_cat;
    logic [NB-1:0]                w_cnt;
    logic                         w_in_acc, w_out_free, w_emit;
    logic                         w_tot_on, w_tot_bit, w_sum_bit;
    logic                         w_add_s, w_add_c;
    logic                         w_num_s, w_num_c;
    logic                         w_nsum_s, w_nsum_c;
    logic                         w_sub_a, w_sub_d, w_sub_bw;

    assign w_op  = s_axis_tuser;
    assign w_cat = s_axis_tdata[CB-1:0];
    assign w_cnt = s_axis_tdata[CB+NB-1:CB];

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_m_grey, r_m_high, r_m_low};

    // serial bit slices
    always_comb begin
        w_tot_on  = (r_bit < hegr_pkg::TOT_LIM);
        w_tot_bit = w_tot_on & r_total[0];
        w_sum_bit = w_tot_on & r_sum[0];
        w_add_s   = r_total[0] ^ r_cnt[0] ^ r_ca;
        w_add_c   = (r_total[0] & r_cnt[0]) | (r_total[0] & r_ca) | (r_cnt[0] & r_ca);
        w_num_s   = r_sd ^ r_cnt[0] ^ r_ca;
        w_num_c   = (r_sd & r_cnt[0]) | (r_sd & r_ca) | (r_cnt[0] & r_ca);
        w_nsum_s  = r_sum[0] ^ r_cnt[0] ^ r_cb;
        w_nsum_c  = (r_sum[0] & r_cnt[0]) | (r_sum[0] & r_cb) | (r_cnt[0] & r_cb);
        w_sub_a   = (r_state == hegr_pkg::ST_PREP) ? w_num_s : r_rd;
        w_sub_d   = w_sub_a ^ r_td ^ r_bw;
        w_sub_bw  = (~w_sub_a & r_td) | (~(w_sub_a ^ r_td) & r_bw);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hegr_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    case (w_op)
                        hegr_pkg::OP_TOTAL:  n_state = hegr_pkg::ST_ADD;
                        hegr_pkg::OP_MAP: begin
                            if ((r_total != '0) && (w_cnt != '0))
                                n_state = hegr_pkg::ST_PREP;
                        end
                        hegr_pkg::OP_FINISH: begin
                            if (r_run_open)
                                n_state = hegr_pkg::ST_EMIT;
                        end
                        default: n_state = hegr_pkg::ST_IDLE;
                    endcase
                end
            end
            hegr_pkg::ST_ADD: begin
                if (r_bit == hegr_pkg::TOT_LAST)
                    n_state = hegr_pkg::ST_IDLE;
            end
            hegr_pkg::ST_PREP: begin
                if (r_bit == hegr_pkg::BIT_LAST)
                    n_state = w_sub_bw ? hegr_pkg::ST_DIV : hegr_pkg::ST_RULE;
            end
            hegr_pkg::ST_DIV: begin
                if ((r_bit == hegr_pkg::BIT_LAST) && (r_step == hegr_pkg::STEP_LAST))
                    n_state = hegr_pkg::ST_RULE;
            end
            hegr_pkg::ST_RULE: begin
                n_state = (r_run_open && (r_q != r_run_level)) ? hegr_pkg::ST_EMIT
                                                                : hegr_pkg::ST_IDLE;
            end
            hegr_pkg::ST_EMIT: begin
                if (w_out_free)
                    n_state = hegr_pkg::ST_IDLE;
            end
            default: n_state = hegr_pkg::ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_axis_tready = (r_state == hegr_pkg::ST_IDLE);
        w_in_acc      = s_axis_tvalid & s_axis_tready;
        w_out_free    = ~r_m_valid | m_axis_tready;
        w_emit        = (r_state == hegr_pkg::ST_EMIT) & w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hegr_pkg::ST_IDLE;
            r_m_valid   <= 1'b0;
            r_total     <= '0;
            r_sum       <= '0;
            r_run_open  <= 1'b0;
            r_run_start <= '0;
            r_run_level <= '0;
            r_last      <= '0;
            r_bit       <= '0;
            r_step      <= '0;
        end else begin
            r_state <= n_state;

            if (w_emit)
                r_m_valid <= 1'b1;
            else if (m_axis_tready)
                r_m_valid <= 1'b0;

            case (r_state)
                hegr_pkg::ST_IDLE: begin
                    if (w_in_acc) begin
                        r_op   <= w_op;
                        r_cat  <= w_cat;
                        r_cnt  <= w_cnt;
                        r_bit  <= '0;
                        r_step <= '0;
                        r_q    <= '0;
                        r_ca   <= 1'b0;
                        r_cb   <= 1'b0;
                        r_bw   <= 1'b0;
                        r_sd   <= 1'b0;
                        r_td   <= 1'b0;
                        r_rd   <= 1'b0;
                        if (w_op == hegr_pkg::OP_MAP)
                            r_last <= w_cat;
                        if ((w_op == hegr_pkg::OP_FINISH) && !r_run_open) begin
                            r_total     <= '0;
                            r_sum       <= '0;
                            r_run_start <= '0;
                            r_run_level <= '0;
                            r_last      <= '0;
                        end
                    end
                end
                hegr_pkg::ST_ADD: begin
                    r_bit <= r_bit + 1'b1;
                    r_ca  <= w_add_c;
                    r_cnt <= {1'b0, r_cnt[NB-1:1]};
                    if ((r_bit == hegr_pkg::TOT_LAST) && w_add_c)
                        r_total <= '1;
                    else
                        r_total <= {w_add_s, r_total[TB-1:1]};
                end
                hegr_pkg::ST_PREP: begin
                    r_cnt <= {1'b0, r_cnt[NB-1:1]};
                    r_ca  <= w_num_c;
                    r_sd  <= w_sum_bit;
                    r_rem <= {w_num_s, r_rem[DB-1:1]};
                    if (w_tot_on) begin
                        r_total <= {r_total[0], r_total[TB-1:1]};
                        r_cb    <= w_nsum_c;
                        if ((r_bit == hegr_pkg::TOT_LAST) && w_nsum_c)
                            r_sum <= '1;
                        else
                            r_sum <= {w_nsum_s, r_sum[TB-1:1]};
                    end
                    if (r_bit == hegr_pkg::BIT_LAST) begin
                        r_bit <= '0;
                        r_bw  <= 1'b0;
                        r_td  <= 1'b0;
                        r_rd  <= 1'b0;
                        if (!w_sub_bw)
                            r_q <= hegr_pkg::GREY_MAX;
                    end else begin
                        r_bit <= r_bit + 1'b1;
                        r_bw  <= w_sub_bw;
                        r_td  <= w_tot_bit;
                    end
                end
                hegr_pkg::ST_DIV: begin
                    if (w_tot_on)
                        r_total <= {r_total[0], r_total[TB-1:1]};
                    if (r_bit == hegr_pkg::BIT_LAST) begin
                        r_bit  <= '0;
                        r_step <= r_step + 1'b1;
                        r_bw   <= 1'b0;
                        r_td   <= 1'b0;
                        r_rd   <= 1'b0;
                        r_q    <= {r_q[GB-2:0], ~w_sub_bw};
                        if (w_sub_bw)
                            r_rem <= {r_rd, r_rem[DB-1:1]};
                        else
                            r_rem <= {w_sub_d, r_dif[DB-1:1]};
                    end else begin
                        r_bit <= r_bit + 1'b1;
                        r_bw  <= w_sub_bw;
                        r_td  <= w_tot_bit;
                        r_rd  <= r_rem[0];
                        r_rem <= {r_rd, r_rem[DB-1:1]};
                        r_dif <= {w_sub_d, r_dif[DB-1:1]};
                    end
                end
                hegr_pkg::ST_RULE: begin
                    r_step <= '0;
                    if (!r_run_open) begin
                        r_run_open  <= 1'b1;
                        r_run_start <= r_cat;
                        r_run_level <= r_q;
                    end
                end
                hegr_pkg::ST_EMIT: begin
                    if (w_out_free) begin
                        r_m_low  <= r_run_start;
                        r_m_grey <= r_run_level;
                        if (r_op == hegr_pkg::OP_FINISH) begin
                            r_m_high    <= r_last;
                            r_total     <= '0;
                            r_sum       <= '0;
                            r_run_open  <= 1'b0;
                            r_run_start <= '0;
                            r_run_level <= '0;
                            r_last      <= '0;
                        end else begin
                            r_m_high    <= r_cat - 1'b1;
                            r_run_start <= r_cat;
                            r_run_level <= r_q;
                        end
                    end
                end
                default: r_bit <= '0;
            endcase
        end
    end

    a_emit_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hegr_pkg::ST_EMIT) |-> r_run_open)
        else $error("rule emit without an open run");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && (r_op == hegr_pkg::OP_FINISH)) |=> (!r_run_open && (r_total == '0)))
        else $error("finish left state behind");

    a_step_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != hegr_pkg::ST_DIV) |-> (r_step == '0))
        else $error("divider step count outside division");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bit <= hegr_pkg::BIT_LAST))
        else $error("bit counter past remainder width");

    a_emit_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (m_axis_tvalid && (r_state == hegr_pkg::ST_IDLE)))
        else $error("rule word not presented after emit");

endmodule

`default_nettype wire
